@@ hw/rtl/mfsk_pkg.sv @@
// ----------------------------------------------------------------------------
// mfsk_pkg
// Shared types, widths, register codes, reset values and the sine helper of
// the multitone FSK modulator.
// ----------------------------------------------------------------------------
package mfsk_pkg;

	// Default structure of the modulator
	localparam int MFSK_GROUPS          = 4;
	localparam int MFSK_BITS_PER_GROUP  = 4;
	localparam int MFSK_PHASE_BITS      = 32;
	localparam int MFSK_SINE_TABLE_BITS = 10;

	// Field and register widths
	localparam int SYMBOL_W     = 16;
	localparam int SAMPLE_W     = 16;
	localparam int SINE_MAG_W   = 15;
	localparam int GROUP_STEP_W = 32;
	localparam int TONE_STEP_W  = 28;
	localparam int SPS_W        = 16;
	localparam int AMP_W        = 15;
	localparam int STEP_REGS    = 4;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 32;

	// Register reset values
	localparam logic [GROUP_STEP_W-1:0] GROUP_STEP_0_RST = 32'd93952410;
	localparam logic [GROUP_STEP_W-1:0] GROUP_STEP_1_RST = 32'd250539759;
	localparam logic [GROUP_STEP_W-1:0] GROUP_STEP_2_RST = 32'd384757487;
	localparam logic [GROUP_STEP_W-1:0] GROUP_STEP_3_RST = 32'd563714458;
	localparam logic [TONE_STEP_W-1:0]  TONE_STEP_RST    = 28'd5592405;
	localparam logic [SPS_W-1:0]        SPS_RST          = 16'd768;
	localparam logic [AMP_W-1:0]        AMP_RST          = 15'd16384;

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GROUP_STEP_0    = 3'd0,
		REG_GROUP_STEP_1    = 3'd1,
		REG_GROUP_STEP_2    = 3'd2,
		REG_GROUP_STEP_3    = 3'd3,
		REG_TONE_STEP       = 3'd4,
		REG_SAMPLES_PER_SYM = 3'd5,
		REG_AMPLITUDE       = 3'd6
	} cfg_reg_t;

	// Q0.15 magnitude of the sine for a position x within the first quadrant,
	// where a quadrant spans 2^(stb-2) positions. Evaluated at elaboration only.
	function automatic logic [SINE_MAG_W-1:0] sine_mag(int unsigned x, int unsigned stb);
		longint unsigned u;
		longint unsigned v;
		longint unsigned t;
		longint unsigned y;
		longint unsigned s;
		u = longint'(x) << (18 - stb);
		v = (u * u) >> 16;
		t = 64'd42047 - ((64'd4640 * v) >> 16);
		t = 64'd102944 - ((v * t) >> 16);
		y = (u * t) >> 16;
		s = (y * 64'd32767 + 64'd32768) >> 16;
		if (s > 64'd32767)
			s = 64'd32767;
		return SINE_MAG_W'(s);
	endfunction

endpackage

@@ hw/rtl/mfsk_if.sv @@
// ----------------------------------------------------------------------------
// mfsk_if
// Valid/ready channels of the modulator: symbol beats in, sample beats out.
// ----------------------------------------------------------------------------
interface mfsk_sym_if;
	import mfsk_pkg::*;

	logic                valid;
	logic                ready;
	logic [SYMBOL_W-1:0] symbol;

	modport source (output valid, output symbol, input ready);
	modport sink   (input valid, input symbol, output ready);
endinterface

interface mfsk_smp_if;
	import mfsk_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       symbol_taken;

	modport source (output valid, output sample, output symbol_taken, input ready);
	modport sink   (input valid, input sample, input symbol_taken, output ready);
endinterface

@@ hw/rtl/multitone_fsk_modulator.sv @@
// ----------------------------------------------------------------------------
// multitone_fsk_modulator
// Every symbol beat is one output tick. At the first tick of a symbol the
// 16-bit symbol is latched, split into one nibble per tone group, Gray-coded,
// and each group's phase step is set to its base step plus tone times the tone
// step. Every tick the sines of the continuous-phase accumulators are summed,
// scaled by amplitude over the number of groups, rounded and saturated into a
// signed 16-bit sample, flagged when that tick latched the symbol. The block
// takes one beat per clock while the output is not stalled and returns one
// sample per beat; each result passes through the four register stages of sine
// lookup and sum, amplitude multiply, reciprocal divide and saturation. A full
// output register that is not taken stalls the whole pipeline and drops ready.
// Register writes are expected only while no beat is in flight.
// ----------------------------------------------------------------------------
module multitone_fsk_modulator #(
	parameter int GROUPS          = mfsk_pkg::MFSK_GROUPS,
	parameter int BITS_PER_GROUP  = mfsk_pkg::MFSK_BITS_PER_GROUP,
	parameter int PHASE_BITS      = mfsk_pkg::MFSK_PHASE_BITS,
	parameter int SINE_TABLE_BITS = mfsk_pkg::MFSK_SINE_TABLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mfsk_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mfsk_pkg::CFG_DATA_W-1:0]  cfg_data,
	mfsk_sym_if.sink                         symbols,
	mfsk_smp_if.source                       samples
);
	import mfsk_pkg::*;

	localparam int QUARTER    = 2 ** (SINE_TABLE_BITS - 2);
	localparam int SYM_EXT_W  = (GROUPS * BITS_PER_GROUP > SYMBOL_W) ?
	                            GROUPS * BITS_PER_GROUP : SYMBOL_W;
	localparam int INC_W      = TONE_STEP_W + BITS_PER_GROUP;
	localparam int WIDE_W     = (INC_W > PHASE_BITS) ? INC_W : PHASE_BITS;
	localparam int SUM_W      = SAMPLE_W + $clog2(GROUPS + 1);
	localparam int PROD_W     = SUM_W + AMP_W + 1;
	// Divide by GROUPS: bias the floored value positive, then multiply by a
	// rounded-up reciprocal. The reciprocal error stays below one step of a.
	localparam int A_W        = $clog2(GROUPS) + 21;
	localparam int BIAS       = GROUPS * (2 ** 19);
	localparam int HALF_D     = GROUPS * (2 ** 14);
	localparam int RECIP_SH   = A_W + 3;
	localparam int RECIP_W    = RECIP_SH + 1;
	localparam int DIV_W      = A_W + RECIP_W;
	localparam int Q_W        = A_W + 2;

	localparam logic [RECIP_W-1:0]      RECIP    = RECIP_W'((2 ** RECIP_SH + GROUPS - 1) / GROUPS);
	localparam logic signed [PROD_W-1:0] HALF_D_P = PROD_W'(HALF_D);
	localparam logic signed [PROD_W-1:0] BIAS_P   = PROD_W'(BIAS);
	localparam logic signed [Q_W-1:0]    BIAS_Q   = Q_W'(BIAS / GROUPS);
	localparam logic signed [Q_W-1:0]    SAT_HI   = Q_W'(SAMPLE_MAX);
	localparam logic signed [Q_W-1:0]    SAT_LO   = Q_W'(SAMPLE_MIN);
	localparam logic [SINE_MAG_W-1:0]   PEAK_MAG = sine_mag(QUARTER, SINE_TABLE_BITS);

	// Configuration registers
	logic [GROUP_STEP_W-1:0] group_step_q [STEP_REGS];
	logic [TONE_STEP_W-1:0]  tone_step_q;
	logic [SPS_W-1:0]        sps_q;
	logic [AMP_W-1:0]        amp_q;

	// Tick state
	logic [PHASE_BITS-1:0] phase_q [GROUPS];
	logic [PHASE_BITS-1:0] step_q  [GROUPS];
	logic [PHASE_BITS-1:0] step_next [GROUPS];
	logic [SPS_W-1:0]      count_q;
	logic [SPS_W-1:0]      count_next;
	logic [SPS_W-1:0]      sps_eff;
	logic [SPS_W:0]        count_inc;
	logic                  latch;
	logic [SYM_EXT_W-1:0]  sym_ext;

	// Pipeline
	logic                       stall;
	logic                       adv;
	logic                       acc;
	logic                       v_s1, v_s2, v_s3, v_s4;
	logic                       taken_s1, taken_s2, taken_s3, taken_s4;
	logic signed [SUM_W-1:0]    sum_s1;
	logic signed [PROD_W-1:0]   p_s2;
	logic [DIV_W-1:0]           div_s3;
	logic signed [SAMPLE_W-1:0] sample_s4;

	logic [SINE_MAG_W-1:0]      sine_lut [QUARTER];
	logic signed [SAMPLE_W-1:0] sin_val [GROUPS];
	logic signed [SUM_W-1:0]    sum_c;
	logic signed [PROD_W-1:0]   n_c;
	logic signed [PROD_W-1:0]   m_c;
	logic [A_W-1:0]             a_c;
	logic [A_W:0]               qu_c;
	logic signed [Q_W-1:0]      q_c;
	logic signed [SAMPLE_W-1:0] sat_c;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_step_q[0] <= GROUP_STEP_0_RST;
			group_step_q[1] <= GROUP_STEP_1_RST;
			group_step_q[2] <= GROUP_STEP_2_RST;
			group_step_q[3] <= GROUP_STEP_3_RST;
			tone_step_q     <= TONE_STEP_RST;
			sps_q           <= SPS_RST;
			amp_q           <= AMP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GROUP_STEP_0:    group_step_q[0] <= cfg_data[GROUP_STEP_W-1:0];
				REG_GROUP_STEP_1:    group_step_q[1] <= cfg_data[GROUP_STEP_W-1:0];
				REG_GROUP_STEP_2:    group_step_q[2] <= cfg_data[GROUP_STEP_W-1:0];
				REG_GROUP_STEP_3:    group_step_q[3] <= cfg_data[GROUP_STEP_W-1:0];
				REG_TONE_STEP:       tone_step_q     <= cfg_data[TONE_STEP_W-1:0];
				REG_SAMPLES_PER_SYM: sps_q           <= cfg_data[SPS_W-1:0];
				REG_AMPLITUDE:       amp_q           <= cfg_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ handshake
	assign stall          = v_s4 & ~samples.ready;
	assign adv            = ~stall;
	assign acc            = symbols.valid & adv;
	assign symbols.ready  = adv;
	assign samples.valid  = v_s4;
	assign samples.sample = sample_s4;
	assign samples.symbol_taken = taken_s4;

	// ------------------------------------------------------- symbol counter
	assign latch      = (count_q == '0);
	assign sps_eff    = (sps_q == '0) ? SPS_W'(1) : sps_q;
	assign count_inc  = {1'b0, count_q} + (SPS_W + 1)'(1);
	assign count_next = (count_inc >= {1'b0, sps_eff}) ? '0 : count_inc[SPS_W-1:0];
	assign sym_ext    = SYM_EXT_W'(symbols.symbol);

	// ------------------------------------------------------ per-group logic
	for (genvar i = 0; i < QUARTER; i++) begin : g_lut
		localparam logic [SINE_MAG_W-1:0] MAG = sine_mag(i, SINE_TABLE_BITS);
		assign sine_lut[i] = MAG;
	end

	for (genvar g = 0; g < GROUPS; g++) begin : g_grp
		logic [BITS_PER_GROUP-1:0]  field;
		logic [BITS_PER_GROUP-1:0]  tone;
		logic [WIDE_W-1:0]          inc;
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [SINE_TABLE_BITS-3:0] r;
		logic [SINE_MAG_W-1:0]      mag;

		assign field = sym_ext[g*BITS_PER_GROUP +: BITS_PER_GROUP];
		assign tone  = field ^ (field >> 1);
		assign inc   = WIDE_W'(tone_step_q) * WIDE_W'(tone);
		assign step_next[g] = latch ?
			group_step_q[g % STEP_REGS][PHASE_BITS-1:0] + inc[PHASE_BITS-1:0] : step_q[g];

		// Odd quadrants mirror the table; their first position is the peak.
		assign idx = phase_q[g][PHASE_BITS-1 -: SINE_TABLE_BITS];
		assign r   = idx[SINE_TABLE_BITS-3:0];
		always_comb begin
			if (!idx[SINE_TABLE_BITS-2])
				mag = sine_lut[r];
			else if (r == '0)
				mag = PEAK_MAG;
			else
				mag = sine_lut[~r + 1'b1];
		end
		assign sin_val[g] = idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, mag})
		                                          : $signed({1'b0, mag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int g = 0; g < GROUPS; g++) begin
				phase_q[g] <= '0;
				step_q[g]  <= '0;
			end
		end else if (acc) begin
			count_q <= count_next;
			for (int g = 0; g < GROUPS; g++) begin
				phase_q[g] <= phase_q[g] + step_next[g];
				step_q[g]  <= step_next[g];
			end
		end
	end

	// ------------------------------------------------------ sample datapath
	always_comb begin
		sum_c = '0;
		for (int g = 0; g < GROUPS; g++)
			sum_c = sum_c + {{(SUM_W - SAMPLE_W){sin_val[g][SAMPLE_W-1]}}, sin_val[g]};
	end

	// Round to nearest by adding half the divisor, floor by 2^15, then by GROUPS.
	assign n_c  = p_s2 + HALF_D_P;
	assign m_c  = n_c >>> 15;
	assign a_c  = A_W'(m_c + BIAS_P);
	assign qu_c = div_s3[DIV_W-1 -: (A_W + 1)];
	assign q_c  = $signed({1'b0, qu_c}) - BIAS_Q;

	always_comb begin
		if (q_c > SAT_HI)
			sat_c = SAMPLE_W'(SAMPLE_MAX);
		else if (q_c < SAT_LO)
			sat_c = SAMPLE_W'(SAMPLE_MIN);
		else
			sat_c = q_c[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1    <= sum_c;
			taken_s1  <= latch;
			p_s2      <= $signed({1'b0, amp_q}) * sum_s1;
			taken_s2  <= taken_s1;
			div_s3    <= DIV_W'(a_c) * DIV_W'(RECIP);
			taken_s3  <= taken_s2;
			sample_s4 <= sat_c;
			taken_s4  <= taken_s3;
		end
	end

endmodule

@@ hw/rtl/mfsk_checker.sv @@
// ----------------------------------------------------------------------------
// mfsk_checker
// Port-level checks of the modulator: output beat hold and beat accounting.
// ----------------------------------------------------------------------------
module mfsk_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [mfsk_pkg::SAMPLE_W-1:0]    sample,
	input logic                                    symbol_taken
);
	import mfsk_pkg::*;

	localparam int DEPTH = 4;

	logic [2:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid & in_ready;
	assign out_beat = out_valid & out_ready;

	// Beats taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (in_beat && !out_beat)
			pending_q <= pending_q + 3'd1;
		else if (!in_beat && out_beat)
			pending_q <= pending_q - 3'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample) && $stable(symbol_taken))
		else $error("output beat changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("output beat without a matching input beat");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'(DEPTH))
		else $error("more beats in flight than pipeline stages");

endmodule

bind multitone_fsk_modulator mfsk_checker u_mfsk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (symbols.valid),
	.in_ready     (symbols.ready),
	.out_valid    (samples.valid),
	.out_ready    (samples.ready),
	.sample       (samples.sample),
	.symbol_taken (samples.symbol_taken)
);

@@ tb/sv/mfsk_sample_check.sv @@
// ----------------------------------------------------------------------------
// mfsk_sample_check
// Watches the symbol, sample and register ports of the multitone FSK
// modulator, keeps its own copy of the tone phases and registers, works out
// the sample due for every symbol beat and compares each sample beat with the
// oldest one due. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module mfsk_sample_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mfsk_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mfsk_pkg::CFG_DATA_W-1:0]  cfg_data,
	mfsk_sym_if                              symbols,
	mfsk_smp_if                              samples,
	output int                               pending,
	output int                               errors
);
	import mfsk_pkg::*;

	localparam int GROUPS     = MFSK_GROUPS;
	localparam int BPG        = MFSK_BITS_PER_GROUP;
	localparam int PHASE_BITS = MFSK_PHASE_BITS;
	localparam int STB        = MFSK_SINE_TABLE_BITS;
	localparam int QUARTER    = 1 << (STB - 2);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       taken;
	} sample_beat_t;

	sample_beat_t due_samples[$];

	logic [GROUP_STEP_W-1:0] group_step [STEP_REGS];
	logic [TONE_STEP_W-1:0]  tone_step;
	logic [SPS_W-1:0]        sym_len;
	logic [AMP_W-1:0]        amp;
	logic [PHASE_BITS-1:0]   phase [GROUPS];
	logic [PHASE_BITS-1:0]   phase_inc [GROUPS];
	int                      tick_in_symbol;
	int                      beats_seen;

	task automatic report_mismatch(input string msg);
		$display("%0t: sample beat %0d: %s", $time, beats_seen, msg);
		errors++;
	endtask

	// Signed Q1.15 sine of a phase word, by quadrant folding and a polynomial.
	function automatic int tone_sine(input logic [PHASE_BITS-1:0] ph);
		logic [STB-1:0]  idx;
		logic [1:0]      quad;
		longint unsigned x;
		longint unsigned u;
		longint unsigned v;
		longint unsigned t;
		longint unsigned y;
		longint unsigned s;
		idx  = ph[PHASE_BITS-1 -: STB];
		quad = idx[STB-1 -: 2];
		x    = idx[STB-3:0];
		if (quad[0])
			x = QUARTER - x;
		u = x << (18 - STB);
		v = (u * u) >> 16;
		t = 64'd42047 - ((64'd4640 * v) >> 16);
		t = 64'd102944 - ((v * t) >> 16);
		y = (u * t) >> 16;
		s = (y * 64'd32767 + 64'd32768) >> 16;
		if (s > 64'd32767)
			s = 64'd32767;
		return quad[1] ? -int'(s) : int'(s);
	endfunction

	task automatic predict_tick(input logic [SYMBOL_W-1:0] sym);
		sample_beat_t          due;
		logic [BPG-1:0]        field;
		logic [PHASE_BITS-1:0] tone_w;
		logic [PHASE_BITS-1:0] step_w;
		longint                tone_sum;
		longint                scaled;
		longint                divisor;
		longint                q;
		int                    sym_period;
		due.taken = (tick_in_symbol == 0);
		if (due.taken) begin
			for (int g = 0; g < GROUPS; g++) begin
				field        = sym[g*BPG +: BPG];
				tone_w       = field ^ (field >> 1);
				step_w       = tone_step;
				phase_inc[g] = group_step[g % STEP_REGS] + tone_w * step_w;
			end
		end
		tone_sum = 0;
		for (int g = 0; g < GROUPS; g++)
			tone_sum += tone_sine(phase[g]);
		divisor = longint'(GROUPS) * 32768;
		scaled  = longint'(amp) * tone_sum + divisor / 2;
		// Division rounding towards minus infinity.
		q = scaled / divisor;
		if (scaled < 0 && (scaled % divisor) != 0)
			q = q - 1;
		if (q > SAMPLE_MAX)
			q = SAMPLE_MAX;
		if (q < SAMPLE_MIN)
			q = SAMPLE_MIN;
		due.sample = q[SAMPLE_W-1:0];
		due_samples.insert(due_samples.size(), due);
		for (int g = 0; g < GROUPS; g++)
			phase[g] = phase[g] + phase_inc[g];
		// A zero symbol length counts as one; a shortened length ends the
		// symbol at once.
		sym_period = (sym_len == '0) ? 1 : int'(sym_len);
		tick_in_symbol++;
		if (tick_in_symbol >= sym_period)
			tick_in_symbol = 0;
	endtask

	task automatic check_sample();
		sample_beat_t due;
		if (due_samples.size() == 0) begin
			report_mismatch("sample beat with nothing due");
		end else begin
			due = due_samples.pop_front();
			if (samples.sample !== due.sample)
				report_mismatch($sformatf("sample %0d, expected %0d",
					samples.sample, due.sample));
			if (samples.symbol_taken !== due.taken)
				report_mismatch($sformatf("symbol_taken %b, expected %b",
					samples.symbol_taken, due.taken));
		end
		beats_seen++;
	endtask

	task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (cfg_reg_t'(idx))
			REG_GROUP_STEP_0, REG_GROUP_STEP_1, REG_GROUP_STEP_2, REG_GROUP_STEP_3: begin
				group_step[idx % STEP_REGS] = data[GROUP_STEP_W-1:0];
			end
			REG_TONE_STEP:       tone_step = data[TONE_STEP_W-1:0];
			REG_SAMPLES_PER_SYM: sym_len   = data[SPS_W-1:0];
			REG_AMPLITUDE:       amp       = data[AMP_W-1:0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_step[0]  = GROUP_STEP_0_RST;
			group_step[1]  = GROUP_STEP_1_RST;
			group_step[2]  = GROUP_STEP_2_RST;
			group_step[3]  = GROUP_STEP_3_RST;
			tone_step      = TONE_STEP_RST;
			sym_len        = SPS_RST;
			amp            = AMP_RST;
			for (int g = 0; g < GROUPS; g++) begin
				phase[g]     = '0;
				phase_inc[g] = '0;
			end
			tick_in_symbol = 0;
			beats_seen     = 0;
			errors         = 0;
			due_samples.delete();
			pending        = 0;
		end else begin
			// A sample beat always belongs to an earlier symbol beat.
			if (samples.valid && samples.ready)
				check_sample();
			if (symbols.valid && symbols.ready)
				predict_tick(symbols.symbol);
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			pending = due_samples.size();
		end
	end

endmodule

@@ tb/sv/tb_multitone_fsk_modulator.sv @@
// ----------------------------------------------------------------------------
// tb_multitone_fsk_modulator
// Drives symbol beats and register settings into the modulator, takes its
// sample beats with random back-pressure, and gives the verdict from the
// mismatch count of the sample checker.
// ----------------------------------------------------------------------------
module tb_multitone_fsk_modulator;
	import mfsk_pkg::*;

	localparam int HALF_PERIOD  = 1;
	localparam int RESET_CYCLES = 10;
	localparam int IDLE_PCT     = 35;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE_GAP   = 6;
	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 1800;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	bit                     no_idle;
	bit                     hold_off;
	int                     pending;
	int                     errors;
	int                     random_sent;
	int                     phase_no;
	int                     burst;

	mfsk_sym_if symbols ();
	mfsk_smp_if samples ();

	multitone_fsk_modulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.symbols   (symbols),
		.samples   (samples)
	);

	mfsk_sample_check sample_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.symbols   (symbols),
		.samples   (samples),
		.pending   (pending),
		.errors    (errors)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Entered and left at a falling edge; valid stays up after the beat.
	task automatic send_symbol(input logic [SYMBOL_W-1:0] sym);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			symbols.valid = 1'b0;
			@(negedge clk);
		end
		symbols.valid  = 1'b1;
		symbols.symbol = sym;
		do
			@(posedge clk);
		while (!symbols.ready);
		@(negedge clk);
	endtask

	// Registers may only change once every sample due has come out.
	task automatic settle();
		symbols.valid = 1'b0;
		wait (pending == 0);
		repeat (SETTLE_GAP) @(negedge clk);
	endtask

	function automatic logic [GROUP_STEP_W-1:0] random_group_step();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic randomise_config();
		int pick;
		if ($urandom_range(1))
			write_reg(REG_GROUP_STEP_0, random_group_step());
		if ($urandom_range(1))
			write_reg(REG_GROUP_STEP_1, random_group_step());
		if ($urandom_range(1))
			write_reg(REG_GROUP_STEP_2, random_group_step());
		if ($urandom_range(1))
			write_reg(REG_GROUP_STEP_3, random_group_step());
		if ($urandom_range(1)) begin
			pick = $urandom_range(9);
			if (pick == 0)
				write_reg(REG_TONE_STEP, '0);
			else if (pick == 1)
				write_reg(REG_TONE_STEP, (1 << TONE_STEP_W) - 1);
			else
				write_reg(REG_TONE_STEP, $urandom & ((1 << TONE_STEP_W) - 1));
		end
		if ($urandom_range(3) != 0) begin
			pick = $urandom_range(99);
			if (pick < 60)
				write_reg(REG_SAMPLES_PER_SYM, $urandom_range(8, 1));
			else if (pick < 85)
				write_reg(REG_SAMPLES_PER_SYM, $urandom_range(64, 9));
			else if (pick < 92)
				write_reg(REG_SAMPLES_PER_SYM, '0);
			else if (pick < 96)
				write_reg(REG_SAMPLES_PER_SYM, (1 << SPS_W) - 1);
			else
				write_reg(REG_SAMPLES_PER_SYM, 1);
		end
		if ($urandom_range(1)) begin
			pick = $urandom_range(99);
			if (pick < 10)
				write_reg(REG_AMPLITUDE, '0);
			else if (pick < 25)
				write_reg(REG_AMPLITUDE, (1 << AMP_W) - 1);
			else
				write_reg(REG_AMPLITUDE, $urandom_range((1 << AMP_W) - 1));
		end
		if ($urandom_range(7) == 0)
			write_reg(REG_SPARE, $urandom);
	endtask

	// Sample side: random back-pressure, or a long hold when asked for.
	initial begin
		samples.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				samples.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
			samples.ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((symbols.valid && symbols.ready) || (samples.valid && samples.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		symbols.valid  = 1'b0;
		symbols.symbol = '0;
		no_idle        = 1'b0;
		hold_off       = 1'b0;
		random_sent    = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: only the first beat latches its symbol.
		send_symbol(16'hFFFF);
		send_symbol(16'h0000);
		send_symbol(16'h8421);
		settle();

		// One sample per symbol at full amplitude; the count left over from the
		// long symbol is cut short by the new length.
		write_reg(REG_GROUP_STEP_0, '1);
		write_reg(REG_GROUP_STEP_1, '0);
		write_reg(REG_GROUP_STEP_2, 32'h8000_0000);
		write_reg(REG_GROUP_STEP_3, 32'h1234_5678);
		write_reg(REG_TONE_STEP, (1 << TONE_STEP_W) - 1);
		write_reg(REG_SAMPLES_PER_SYM, 1);
		write_reg(REG_AMPLITUDE, (1 << AMP_W) - 1);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_symbol(16'h0000);
		send_symbol(16'hFFFF);
		for (int i = 0; i < 16; i += 2)
			send_symbol({4'(i), 4'(i + 1), 4'(15 - i), 4'(14 - i)});
		settle();

		// Symbol length shortened in the middle of a symbol.
		write_reg(REG_SAMPLES_PER_SYM, 7);
		write_reg(REG_TONE_STEP, '0);
		write_reg(REG_AMPLITUDE, 12345);
		send_symbol(16'h1357);
		send_symbol(16'h2468);
		send_symbol(16'h9BDF);
		settle();
		write_reg(REG_SAMPLES_PER_SYM, 2);
		send_symbol(16'hACE0);
		send_symbol(16'h5A5A);
		send_symbol(16'hA5A5);
		settle();

		// A zero symbol length latches on every beat; zero amplitude too.
		write_reg(REG_SAMPLES_PER_SYM, '0);
		write_reg(REG_AMPLITUDE, '0);
		send_symbol(16'h0F0F);
		send_symbol(16'hF0F0);
		send_symbol(16'h7777);
		settle();

		phase_no = 0;
		while (random_sent < RANDOM_ITEMS) begin
			randomise_config();
			no_idle  = (phase_no == 3);
			hold_off = (phase_no == 1 || phase_no == 8);
			burst    = $urandom_range(160, 60);
			repeat (burst) begin
				send_symbol(SYMBOL_W'($urandom));
				random_sent++;
			end
			settle();
			no_idle = 1'b0;
			phase_no++;
		end

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
